@@ hw/rtl/rlp_pkg.sv @@
// ----------------------------------------------------------------------------
// rlp_pkg
// Shared types and constants of the reflectance line parser.
// ----------------------------------------------------------------------------
package rlp_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_MAX_VALUE = 1'b0;
    localparam logic REG_MAX_LINE  = 1'b1;

    localparam logic [15:0] MAX_VALUE_RESET = 16'd65000;
    localparam logic [5:0]  MAX_LINE_RESET  = 6'd16;

    localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0]  CHAR_COMMA   = 8'h2C;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  CHAR_NINE    = 8'h39;

    localparam logic [16:0] GREEN_SATURATE = 17'd65001;

    // Positions within a line.
    localparam logic [5:0]  POS_COMMA      = 6'd5;
    localparam logic [5:0]  POS_SECOND_END = 6'd10;
    localparam logic [5:0]  PAIR_LEN       = 6'd11;
    localparam logic [5:0]  PREFIX_LEN     = 6'd6;

    localparam logic KIND_PAIR  = 1'b0;
    localparam logic KIND_FAULT = 1'b1;

    typedef struct packed {
        logic [15:0] max_value;
        logic [5:0]  max_line;
    } rlp_cfg_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] red;
        logic [15:0] green;
    } rlp_event_t;

    // Characters of the acknowledgement word "setLED".
    function automatic logic [7:0] led_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h73;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h4C;
            3'd4:    ch = 8'h45;
            3'd5:    ch = 8'h44;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ hw/rtl/reflectance_line_parser_core.sv @@
// ----------------------------------------------------------------------------
// reflectance_line_parser_core
// Splits a serial byte stream into lines and reports reflectance pairs
// and bad-data faults with a running report count.
// ----------------------------------------------------------------------------
//   Channel   Handshake           Payload
//   input     in_valid/in_ready   rx_byte
//   output    out_valid/out_ready event_kind, red_value, green_value, report_count
//   config    APB psel/penable    max_value at 0x0, max_line at 0x4
//
// One byte is accepted every cycle while the report queue has room; the
// classifier keeps a small running line state.
// A report is queued on its newline beat, then popped into the output register.
// Reset clears the line state, the queue and the report count at once.
// A stalled output fills the queue of QUEUE_DEPTH reports before in_ready drops.
// ----------------------------------------------------------------------------
module reflectance_line_parser_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            event_kind,
    output logic [15:0]                     red_value,
    output logic [15:0]                     green_value,
    output logic [31:0]                     report_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rlp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rlp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rlp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import rlp_pkg::*;

    rlp_cfg_t   cfg_reg;
    rlp_event_t push_event;
    rlp_event_t head_event;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_value <= MAX_VALUE_RESET;
            cfg_reg.max_line  <= MAX_LINE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MAX_VALUE)
                cfg_reg.max_value <= pwdata[15:0];
            else
                cfg_reg.max_line <= pwdata[5:0];
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAX_VALUE: prdata = {16'd0, cfg_reg.max_value};
            REG_MAX_LINE:  prdata = {26'd0, cfg_reg.max_line};
            default:       prdata = '0;
        endcase
    end

    rlp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .q_full     (q_full),
        .push       (push),
        .push_event (push_event)
    );

    rlp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .pop        (pop),
        .head_event (head_event),
        .empty      (q_empty),
        .full       (q_full)
    );

    rlp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_event   (head_event),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .red_value    (red_value),
        .green_value  (green_value),
        .report_count (report_count)
    );

endmodule

@@ hw/rtl/rlp_front.sv @@
// ----------------------------------------------------------------------------
// rlp_front
// Takes one byte per beat, tracks the current line and classifies each
// completed line into a report or nothing.
// ----------------------------------------------------------------------------
module rlp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  rlp_pkg::rlp_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                q_full,
    output logic                push,
    output rlp_pkg::rlp_event_t push_event
);
    import rlp_pkg::*;

    logic [5:0]  pos_reg, pos_next;
    logic        first_pending_reg, first_pending_next;
    logic        pair_ok_reg, pair_ok_next;
    logic        prefix_ok_reg, prefix_ok_next;
    logic [16:0] first_num_reg, first_num_next;
    logic [16:0] second_num_reg, second_num_next;
    logic        second_done_reg, second_done_next;

    logic        take;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [20:0] first_mac;
    logic [20:0] second_mac;
    logic [6:0]  pos_inc;
    logic [16:0] green_sat;
    logic        pair_line;
    logic        ack_line;
    logic        in_range;

    assign in_ready  = !q_full;
    assign take      = in_valid && in_ready;
    assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit_val = is_digit ? rx_byte[3:0] : 4'd0;
    assign first_mac  = 21'(first_num_reg) * 21'd10 + 21'(digit_val);
    assign second_mac = 21'(second_num_reg) * 21'd10 + 21'(digit_val);
    assign pos_inc    = {1'b0, pos_reg} + 7'd1;

    assign green_sat = (second_num_reg > GREEN_SATURATE) ? GREEN_SATURATE : second_num_reg;
    assign pair_line = pair_ok_reg && (pos_reg >= PAIR_LEN);
    assign ack_line  = prefix_ok_reg && (pos_reg >= PREFIX_LEN);
    assign in_range  = (first_num_reg <= {1'b0, cfg.max_value})
                    && (green_sat <= {1'b0, cfg.max_value});

    always_comb
    begin
        push             = 1'b0;
        push_event.kind  = pair_line ? KIND_PAIR : KIND_FAULT;
        push_event.red   = pair_line ? first_num_reg[15:0] : 16'd0;
        push_event.green = pair_line ? green_sat[15:0] : 16'd0;

        pos_next           = pos_reg;
        first_pending_next = first_pending_reg;
        pair_ok_next       = pair_ok_reg;
        prefix_ok_next     = prefix_ok_reg;
        first_num_next     = first_num_reg;
        second_num_next    = second_num_reg;
        second_done_next   = second_done_reg;

        if (take)
        begin
            if (rx_byte == CHAR_NEWLINE)
            begin
                if (first_pending_reg)
                begin
                    first_pending_next = 1'b0;
                end
                else if (pair_line)
                begin
                    push = in_range;
                end
                else if (!ack_line)
                begin
                    push = 1'b1;
                end
                pos_next         = 6'd0;
                pair_ok_next     = 1'b1;
                prefix_ok_next   = 1'b1;
                first_num_next   = 17'd0;
                second_num_next  = 17'd0;
                second_done_next = 1'b0;
            end
            else
            begin
                if (pos_reg < POS_COMMA)
                begin
                    if (is_digit)
                        first_num_next = first_mac[16:0];
                    else
                        pair_ok_next = 1'b0;
                end
                else if (pos_reg == POS_COMMA)
                begin
                    if (rx_byte != CHAR_COMMA)
                        pair_ok_next = 1'b0;
                end
                else if (pos_reg <= POS_SECOND_END)
                begin
                    if (is_digit)
                        second_num_next = second_mac[16:0];
                    else
                        pair_ok_next = 1'b0;
                end
                else if (!second_done_reg)
                begin
                    if (is_digit)
                        second_num_next = (second_mac > 21'(GREEN_SATURATE))
                                        ? GREEN_SATURATE : second_mac[16:0];
                    else
                        second_done_next = 1'b1;
                end

                if ((pos_reg < PREFIX_LEN) && (rx_byte != led_char(pos_reg[2:0])))
                    prefix_ok_next = 1'b0;

                // The byte that overruns the limit throws away the whole line.
                if (pos_inc > {1'b0, cfg.max_line})
                begin
                    pos_next         = 6'd0;
                    pair_ok_next     = 1'b1;
                    prefix_ok_next   = 1'b1;
                    first_num_next   = 17'd0;
                    second_num_next  = 17'd0;
                    second_done_next = 1'b0;
                end
                else
                begin
                    pos_next = pos_inc[5:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= 6'd0;
            first_pending_reg <= 1'b1;
            pair_ok_reg       <= 1'b1;
            prefix_ok_reg     <= 1'b1;
            first_num_reg     <= 17'd0;
            second_num_reg    <= 17'd0;
            second_done_reg   <= 1'b0;
        end
        else
        begin
            pos_reg           <= pos_next;
            first_pending_reg <= first_pending_next;
            pair_ok_reg       <= pair_ok_next;
            prefix_ok_reg     <= prefix_ok_next;
            first_num_reg     <= first_num_next;
            second_num_reg    <= second_num_next;
            second_done_reg   <= second_done_next;
        end
    end

endmodule

@@ hw/rtl/rlp_queue.sv @@
// ----------------------------------------------------------------------------
// rlp_queue
// Small first-in first-out queue of pending reports between the line
// classifier and the report stage.
// ----------------------------------------------------------------------------
module rlp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rlp_pkg::rlp_event_t push_event,
    input  logic                pop,
    output rlp_pkg::rlp_event_t head_event,
    output logic                empty,
    output logic                full
);
    import rlp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rlp_event_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign empty      = (count_reg == CNT_W'(0));
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_event = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_event;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/rlp_back.sv @@
// ----------------------------------------------------------------------------
// rlp_back
// Takes queued reports, stamps them with the running report count and
// holds each in the output register until it is taken.
// ----------------------------------------------------------------------------
module rlp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  rlp_pkg::rlp_event_t head_event,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                event_kind,
    output logic [15:0]         red_value,
    output logic [15:0]         green_value,
    output logic [31:0]         report_count
);
    import rlp_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] counter_reg, counter_next;
    rlp_event_t  event_reg;

    assign pop = !q_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        counter_next   = counter_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            counter_next   = counter_reg + 32'd1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            counter_reg   <= 32'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            counter_reg   <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            event_reg <= head_event;
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = event_reg.kind;
    assign red_value    = event_reg.red;
    assign green_value  = event_reg.green;
    assign report_count = counter_reg;

endmodule

@@ hw/rtl/rlp_checker.sv @@
// ----------------------------------------------------------------------------
// rlp_checker
// Port-level checks of the reflectance line parser, bound to the top level.
// ----------------------------------------------------------------------------
module rlp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        event_kind,
    input logic [15:0] red_value,
    input logic [15:0] green_value,
    input logic [31:0] report_count,
    input logic        pready
);
    import rlp_pkg::*;

    // A stalled beat keeps its whole report.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(report_count)
            && $stable(red_value) && $stable(green_value) && $stable(event_kind))
    else $error("stalled output beat changed");

    // A fault report carries zero values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == KIND_FAULT) |-> (red_value == 16'd0) && (green_value == 16'd0))
    else $error("fault report with nonzero values");

    // The green value never goes past its saturation point.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == KIND_PAIR) |-> {1'b0, green_value} <= GREEN_SATURATE)
    else $error("green value above saturation");

    assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind reflectance_line_parser_core rlp_checker u_rlp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .red_value    (red_value),
    .green_value  (green_value),
    .report_count (report_count),
    .pready       (pready)
);

@@ dv/reflectance_line_parser_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reflectance_line_parser_core_test
// Drives serial bytes into the line parser under random stalls on both
// channels and several register settings, predicts every report from a
// running copy of the line state, and checks each report field by field.
// ----------------------------------------------------------------------------
module reflectance_line_parser_core_test;

    import rlp_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;

    typedef struct packed {
        logic        kind;
        logic [15:0] red;
        logic [15:0] green;
        logic [31:0] count;
    } report_t;

    // Running copy of the line state; it turns accepted bytes into the
    // reports that the block must produce, in order.
    class reflectance_reports;
        logic [15:0] max_value;
        logic [5:0]  max_line;
        int unsigned line_pos;
        bit          first_line_pending;
        bit          pair_ok;
        bit          ack_ok;
        bit          green_done;
        int unsigned red_acc;
        int unsigned green_acc;
        logic [31:0] report_total;
        report_t     due_reports[$];
        int          mismatches;
        int          pair_reports;
        int          fault_reports;
        string       ack_word = "setLED";

        function void clear_line();
            line_pos   = 0;
            pair_ok    = 1'b1;
            ack_ok     = 1'b1;
            green_done = 1'b0;
            red_acc    = 0;
            green_acc  = 0;
        endfunction

        function void reset_state();
            max_value          = MAX_VALUE_RESET;
            max_line           = MAX_LINE_RESET;
            first_line_pending = 1'b1;
            report_total       = '0;
            due_reports.delete();
            clear_line();
        endfunction

        function void issue(logic kind, logic [15:0] red, logic [15:0] green);
            report_t rep;
            report_total++;
            rep.kind  = kind;
            rep.red   = red;
            rep.green = green;
            rep.count = report_total;
            due_reports.push_back(rep);
        endfunction

        function void take_byte(logic [7:0] b);
            bit          is_digit;
            int unsigned digit;
            int unsigned green;
            if (b == CHAR_NEWLINE)
            begin
                if (first_line_pending)
                    first_line_pending = 1'b0;
                else if (pair_ok && line_pos >= PAIR_LEN)
                begin
                    green = (green_acc > GREEN_SATURATE) ? GREEN_SATURATE : green_acc;
                    // An out-of-range pair is swallowed and the count stays put.
                    if (red_acc <= max_value && green <= max_value)
                        issue(KIND_PAIR, 16'(red_acc), 16'(green));
                end
                else if (!(ack_ok && line_pos >= PREFIX_LEN))
                    issue(KIND_FAULT, '0, '0);
                clear_line();
                return;
            end
            is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
            digit    = is_digit ? int'(b - CHAR_ZERO) : 0;
            if (line_pos < POS_COMMA)
            begin
                if (is_digit)
                    red_acc = red_acc * 10 + digit;
                else
                    pair_ok = 1'b0;
            end
            else if (line_pos == POS_COMMA)
            begin
                if (b != CHAR_COMMA)
                    pair_ok = 1'b0;
            end
            else if (line_pos <= POS_SECOND_END)
            begin
                if (is_digit)
                    green_acc = green_acc * 10 + digit;
                else
                    pair_ok = 1'b0;
            end
            else if (!green_done)
            begin
                // Digits past the fixed field keep extending green, clamped.
                if (is_digit)
                begin
                    green_acc = green_acc * 10 + digit;
                    if (green_acc > GREEN_SATURATE)
                        green_acc = GREEN_SATURATE;
                end
                else
                    green_done = 1'b1;
            end
            if (line_pos < PREFIX_LEN && b != ack_word[line_pos])
                ack_ok = 1'b0;
            // The byte that pushes the line past max_line drops all of it.
            if (line_pos + 1 > max_line)
                clear_line();
            else
                line_pos++;
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(logic kind, logic [15:0] red, logic [15:0] green,
                                   logic [31:0] count);
            report_t want;
            if (due_reports.size() == 0)
            begin
                $display("%0t: report with none expected: expected nothing, actual kind %0d red %0d green %0d count %0d",
                         $time, kind, red, green, count);
                mismatches++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("event_kind", 32'(want.kind), 32'(kind));
            compare_field("red_value", 32'(want.red), 32'(red));
            compare_field("green_value", 32'(want.green), 32'(green));
            compare_field("report_count", want.count, count);
            if (want.kind == KIND_PAIR)
                pair_reports++;
            else
                fault_reports++;
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             rx_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic                   event_kind;
    logic [15:0]            red_value;
    logic [15:0]            green_value;
    logic [31:0]            report_count;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    reflectance_reports reports;
    bit          steady_send;
    bit          hold_off_req;
    bit          hold_active;
    int unsigned bytes_sent;
    int unsigned lines_sent;
    int          settings_used;
    int          cfg_mismatches;
    int          errors;

    reflectance_line_parser_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .red_value    (red_value),
        .green_value  (green_value),
        .report_count (report_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Values cluster at and around max_value so both sides of the limit show up.
    function automatic int pick_value();
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 99999);
            1:       v = int'(reports.max_value) + int'($urandom_range(0, 2)) - 1;
            default: v = $urandom_range(0, int'(reports.max_value));
        endcase
        if (v < 0)
            v = 0;
        if (v > 99999)
            v = 99999;
        return v;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                reports.take_byte(rx_byte);
            if (out_valid && out_ready)
                reports.check_report(event_kind, red_value, green_value, report_count);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_line(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
        send_byte(CHAR_NEWLINE);
        lines_sent++;
    endtask

    // Stop offering bytes until every predicted report has been taken.
    task automatic drain_reports();
        in_valid <= 1'b0;
        do
        begin
            while (reports.due_reports.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (reports.due_reports.size() != 0);
    endtask

    // Write one register, then read it back in the following transfer.
    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            $display("%0t: readback of register %0d: expected %0d, actual %0d",
                     $time, idx, value, prdata);
            cfg_mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] value_limit, input logic [5:0] line_limit);
        drain_reports();
        write_reg(REG_MAX_VALUE, APB_DATA_W'(value_limit));
        write_reg(REG_MAX_LINE, APB_DATA_W'(line_limit));
        reports.max_value = value_limit;
        reports.max_line  = line_limit;
        settings_used++;
    endtask

    task automatic random_line();
        string      text;
        int         kind_pick;
        int         spot;
        logic [7:0] ch;
        kind_pick   = $urandom_range(0, 99);
        steady_send = ($urandom_range(0, 4) == 0);
        text        = "";
        if (kind_pick < 50)
        begin
            text = $sformatf("%05d,%05d", pick_value(), pick_value());
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6))
                    text = {text, $sformatf("%0d", $urandom_range(0, 9))};
            if ($urandom_range(0, 4) == 0)
                text = {text, $sformatf("%c", $urandom_range(33, 126))};
            // A slice of the pairs gets one character corrupted.
            if (kind_pick >= 40)
            begin
                spot = $urandom_range(0, 10);
                ch   = 8'($urandom_range(1, 255));
                if (ch == CHAR_NEWLINE)
                    ch = CHAR_COMMA;
                text.putc(spot, ch);
            end
            send_line(text);
        end
        else if (kind_pick < 62)
        begin
            text = ($urandom_range(0, 3) == 0) ? "setLEX" : "setLED";
            repeat ($urandom_range(0, 4))
                text = {text, $sformatf("%c", $urandom_range(32, 126))};
            send_line(text);
        end
        else if (kind_pick < 74)
        begin
            repeat ($urandom_range(0, 10))
                text = {text, $sformatf("%c", $urandom_range(32, 126))};
            send_line(text);
        end
        else if (kind_pick < 92)
        begin
            repeat ($urandom_range(1, 24))
                send_byte(8'($urandom_range(0, 255)));
            send_line("");
        end
        else
        begin
            repeat (int'(reports.max_line) + $urandom_range(1, 6))
                text = {text, $sformatf("%0d", $urandom_range(0, 9))};
            send_line(text);
        end
    endtask

    task automatic random_phase(input int unsigned amount);
        int unsigned stop_at;
        stop_at = bytes_sent + amount;
        while (bytes_sent < stop_at)
            random_line();
        steady_send = 1'b0;
    endtask

    // Output held off while empty lines keep coming, so the report queue
    // fills and the input side has to stall.
    task automatic pressure_burst();
        in_valid     <= 1'b0;
        hold_off_req = 1'b1;
        wait (hold_active);
        @(posedge clk);
        steady_send = 1'b1;
        repeat (40) send_line("");
        steady_send = 1'b0;
        drain_reports();
    endtask

    initial
    begin : result_sink
        int stall;
        int run;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_active  = 1'b1;
                stall        = HOLD_OFF_CYCLES;
            end
            else
                stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            hold_active = 1'b0;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : 1;
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no beat on any port for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        reports = new();
        reports.reset_state();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        out_ready <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(MAX_VALUE_RESET, MAX_LINE_RESET);
        // A good pair as the very first line must still be thrown away.
        send_line("12345,12345");
        send_line("");
        send_line("00000,00000");
        send_line("65000,65000");
        send_line("65001,00001");
        send_line("00001,65001");
        send_line("setLED");
        send_line("setLE");
        send_line("12345,6789");
        send_byte(8'h00);
        send_line("2345,12345");
        send_line("12345,12345abc");
        send_line("12345678901234567");

        set_config(16'd65535, 6'd62);
        send_line("00007,1234567890");
        send_line("65535,99999");

        set_config(16'd65001, 6'd11);
        send_line("00000,99999");
        send_line("12345,12345");
        send_line("12345,123456");

        set_config(16'd0, 6'd0);
        send_line("abc");

        set_config(16'd0, 6'd11);
        send_line("00000,00000");
        send_line("00000,00001");

        set_config(MAX_VALUE_RESET, MAX_LINE_RESET);
        random_phase(60);
        pressure_burst();

        set_config(16'd65535, 6'd62);
        random_phase(50);

        set_config(16'd0, 6'($urandom_range(11, 62)));
        random_phase(50);

        set_config(16'($urandom_range(0, 65535)), 6'd11);
        random_phase(50);

        drain_reports();
        errors = reports.mismatches + cfg_mismatches + reports.due_reports.size();
        $display("Sent %0d bytes in %0d lines under %0d register settings, with one long output stall.",
                 bytes_sent, lines_sent, settings_used);
        $display("Checked %0d pair reports and %0d fault reports.",
                 reports.pair_reports, reports.fault_reports);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ reflectance_line_parser_core.f @@
hw/rtl/rlp_pkg.sv
hw/rtl/rlp_front.sv
hw/rtl/rlp_queue.sv
hw/rtl/rlp_back.sv
hw/rtl/reflectance_line_parser_core.sv
hw/rtl/rlp_checker.sv
dv/reflectance_line_parser_core_test.sv
